/* rtl/lifegen_pkg.sv */
package lifegen_pkg;

  localparam int XW = 7;

  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 40;
  localparam int ROW_W = 5;
  localparam int CELLS_W = 32;
  localparam int CFG_W = 6;

  localparam logic [CFG_W-1:0] SIZE_RESET = 6'd20;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam logic [1:0] STATUS_SET = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_ROW = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEED = 3'b010,
    ST_STEP = 3'b100
  } state_t;

endpackage

/* rtl/lifegen_ram.sv */
module lifegen_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/lifegen_rule.sv */
module lifegen_rule #(
  parameter int COLS = 32
) (
  input  logic [COLS-1:0] up,
  input  logic [COLS-1:0] cur,
  input  logic [COLS-1:0] dn,
  input  logic [COLS-1:0] mask,
  output logic [COLS-1:0] nxt
);

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    logic l_up, l_cur, l_dn, r_up, r_cur, r_dn;
    logic [3:0] cnt;

    if (c > 0) begin : g_left
      assign {l_up, l_cur, l_dn} = {up[c-1], cur[c-1], dn[c-1]};
    end else begin : g_left_edge
      assign {l_up, l_cur, l_dn} = 3'b000;
    end

    if (c < COLS - 1) begin : g_right
      assign {r_up, r_cur, r_dn} = {up[c+1], cur[c+1], dn[c+1]};
    end else begin : g_right_edge
      assign {r_up, r_cur, r_dn} = 3'b000;
    end

    assign cnt = {3'b000, l_up} + {3'b000, l_cur} + {3'b000, l_dn}
               + {3'b000, up[c]} + {3'b000, dn[c]}
               + {3'b000, r_up} + {3'b000, r_cur} + {3'b000, r_dn};

    assign nxt[c] = mask[c] && ((cnt == 4'd3) || ((cnt == 4'd2) && cur[c]));
  end

endmodule

/* rtl/life_automaton_generation_top.sv */
// Channel   Direction  Signals                         Fields (lowest bit first)
// s_*       in         s_tvalid s_tready s_tdata       row[4:0] col[9:5]
//                      s_tuser                         func
// m_*       out        m_tvalid m_tready m_tdata       row_index[4:0] row_cells[36:5]
//                      m_tuser m_tlast                 status; last
// cfg_*     in         cfg_we cfg_index cfg_data       rows_in_use (0), cols_in_use (1)
//
// A seed transfer does one board memory read, then the write-back.
// A step transfer reads the board memory one row per cycle, holding while a result waits
// in the output register, and each new row is written back and emitted as it is made.
// Reset clears all per-row valid flags at once; there is no clearing pass.
// A result waits in the output register; a step holds its row sweep while it waits.
module life_automaton_generation_top
  import lifegen_pkg::*;
#(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // row, col, zero padding
  input  logic                  s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // row_index, row_cells, zero padding
  output logic [1:0]            m_tuser,   // status
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int VD = 2 ** AW;

  state_t state;
  logic [CFG_W-1:0] rows_reg, cols_reg;
  logic [XW-1:0] rows_eff, cols_eff;
  logic [MAX_COLS-1:0] col_mask;
  logic [VD-1:0] row_mask;

  logic [ROW_W-1:0] in_row, in_col;
  logic [XW-1:0] in_row_x;
  logic accept, slot_free;

  logic [ROW_W-1:0] seed_row, seed_col;
  logic [XW-1:0] seed_row_x;
  logic seed_reject, seed_go;

  logic [XW-1:0] n, nm2;
  logic step_adv, emit_step, step_last;

  logic rd_ok;
  logic ram_re, ram_we;
  logic [AW-1:0] ram_raddr, ram_waddr;
  logic [MAX_COLS-1:0] ram_rdata, ram_wdata;
  logic [MAX_COLS-1:0] rd_raw, rd_in, mid_row, dn_row, rule_out, seed_raw;

  logic [VD-1:0] vld, vld_next;

  logic [1:0] out_status;
  logic [ROW_W-1:0] out_index;
  logic [CELLS_W-1:0] out_cells;
  logic out_last;

  always_comb begin
    if (rows_reg == '0) begin
      rows_eff = XW'(1);
    end else if (XW'(rows_reg) > XW'(MAX_ROWS)) begin
      rows_eff = XW'(MAX_ROWS);
    end else begin
      rows_eff = XW'(rows_reg);
    end
    if (cols_reg == '0) begin
      cols_eff = XW'(1);
    end else if (XW'(cols_reg) > XW'(MAX_COLS)) begin
      cols_eff = XW'(MAX_COLS);
    end else begin
      cols_eff = XW'(cols_reg);
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = XW'(c) < cols_eff;
    end
    for (int r = 0; r < VD; r++) begin
      row_mask[r] = XW'(r) < rows_eff;
    end
  end

  assign in_row = s_tdata[4:0];
  assign in_col = s_tdata[9:5];
  assign in_row_x = XW'(in_row);
  assign seed_row_x = XW'(seed_row);

  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  assign nm2 = n - XW'(2);
  assign step_adv = (state == ST_STEP) && ((n < XW'(2)) || slot_free);
  assign emit_step = step_adv && (n >= XW'(2));
  assign step_last = (n == rows_eff + XW'(1));
  assign seed_go = (state == ST_SEED) && slot_free;

  assign rd_raw = rd_ok ? ram_rdata : '0;
  assign rd_in = rd_raw & col_mask;
  assign seed_raw = rd_raw | ({{(MAX_COLS-1){1'b0}}, 1'b1} << seed_col);

  assign ram_re = accept || step_adv;
  assign ram_raddr = (state == ST_IDLE) ? in_row_x[AW-1:0] : n[AW-1:0];
  assign ram_we = emit_step || (seed_go && !seed_reject);
  assign ram_waddr = (state == ST_STEP) ? nm2[AW-1:0] : seed_row_x[AW-1:0];
  assign ram_wdata = (state == ST_STEP) ? rule_out : seed_raw;

  lifegen_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_board (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lifegen_rule #(
    .COLS(MAX_COLS)
  ) u_rule (
    .up  (mid_row),
    .cur (dn_row),
    .dn  (rd_in),
    .mask(col_mask),
    .nxt (rule_out)
  );

  always_comb begin
    vld_next = vld;
    if (ram_we) begin
      vld_next[ram_waddr] = 1'b1;
    end
    if (emit_step && step_last) begin
      vld_next = vld_next & row_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rows_reg <= SIZE_RESET;
      cols_reg <= SIZE_RESET;
      vld <= '0;
      rd_ok <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      vld <= vld_next;
      if (cfg_we) begin
        if (cfg_index == REG_ROWS) begin
          rows_reg <= cfg_data;
        end else begin
          cols_reg <= cfg_data;
        end
      end
      if (ram_re) begin
        if (state == ST_IDLE) begin
          rd_ok <= (s_tuser == FUNC_SEED) && vld[in_row_x[AW-1:0]];
        end else begin
          rd_ok <= (n < rows_eff) && vld[n[AW-1:0]];
        end
      end
      if (emit_step || seed_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (s_tuser == FUNC_STEP) ? ST_STEP : ST_SEED;
          end
        end
        ST_SEED: begin
          if (seed_go) begin
            state <= ST_IDLE;
          end
        end
        ST_STEP: begin
          if (emit_step && step_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seed_row <= in_row;
      seed_col <= in_col;
      seed_reject <= (in_row_x >= rows_eff) || (XW'(in_col) >= cols_eff);
      n <= '0;
    end
    if (step_adv) begin
      n <= n + XW'(1);
      mid_row <= dn_row;
      dn_row <= rd_in;
    end
    if (emit_step) begin
      out_status <= STATUS_ROW;
      out_index <= nm2[ROW_W-1:0];
      out_cells <= CELLS_W'(rule_out);
      out_last <= step_last;
    end else if (seed_go) begin
      out_status <= seed_reject ? STATUS_REJECT : STATUS_SET;
      out_index <= seed_row;
      out_cells <= seed_reject ? '0 : CELLS_W'(seed_raw & col_mask);
      out_last <= 1'b1;
    end
  end

  assign m_tdata = {3'b000, out_cells, out_index};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule

/* rtl/lifegen_check.sv */
module lifegen_check
  import lifegen_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]            m_tuser,
  input logic                  m_tlast
);

  // A held result must not change under the sink.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("held result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_seed_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STATUS_SET || m_tuser == STATUS_REJECT) |-> m_tlast)
    else $error("seed result without last");

  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STATUS_REJECT) |-> (m_tdata[36:5] == '0))
    else $error("rejected seed shows cells");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == STATUS_SET || m_tuser == STATUS_REJECT
      || m_tuser == STATUS_ROW))
    else $error("unknown status code");

endmodule

bind life_automaton_generation_top lifegen_check u_lifegen_check (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
